[design/mchw_pkg.sv]
// Package for the multi-channel heartbeat watchdog: sizes, codes and types.
// No dependencies; every design file except mchw_ram imports it.
package mchw_pkg;

  // Sizes
  localparam int CHANNELS   = 4;
  localparam int COUNT_BITS = 17;
  localparam int LIMIT_W    = 16;
  localparam int LIMIT_REGS = 4;
  localparam int LIM_IDX_W  = 2;
  localparam int CH_W       = 2;
  localparam int KIND_W     = 2;
  localparam int ACT_W      = 3;
  localparam int MASK_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ADDR_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  // Input operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BEAT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT3 = 3'd5;

  // Event kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_BEAT    = 2'd0,
    KIND_PRE     = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DRAIN
  } mchw_state_t;

endpackage

[design/mchw_in_if.sv]
// Input channel interface of the heartbeat watchdog (tick or heartbeat beats).
// Depends on mchw_pkg.
interface mchw_in_if import mchw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            operation;
  logic [CH_W-1:0] channel;
  logic            enable_flag;

  modport source (output valid, operation, channel, enable_flag, input ready);
  modport sink   (input valid, operation, channel, enable_flag, output ready);
endinterface

[design/mchw_out_if.sv]
// Result channel interface of the heartbeat watchdog (event beats).
// Depends on mchw_pkg.
interface mchw_out_if import mchw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   event_channel;
  logic [KIND_W-1:0] event_kind;
  logic              last_event;

  modport source (output valid, event_channel, event_kind, last_event, input ready);
  modport sink   (input valid, event_channel, event_kind, last_event, output ready);
endinterface

[design/mchw_cfg_if.sv]
// Configuration write interface of the heartbeat watchdog.
// Depends on mchw_pkg.
interface mchw_cfg_if import mchw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[design/mchw_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mchw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[design/multi_channel_heartbeat_watchdog.sv]
// Multi-channel heartbeat watchdog top level: sequencer, flags, event buffer.
// Depends on mchw_pkg, mchw_in_if, mchw_out_if, mchw_cfg_if and mchw_ram.
//
//  port    | dir  | beat contents
//  --------+------+---------------------------------------------
//  in_ch   | sink | operation, channel, enable_flag
//  out_ch  | src  | event_channel, event_kind, last_event
//  cfg_ch  | sink | reg_index, wdata (always ready)
//
// A heartbeat is accepted in idle, then its event beat is delivered in the drain state.
// A tick is accepted, then the scan reads and updates the idle count of each channel in
// use (up to 4), one entry per cycle, then a flush state, then the drain state delivers its event beats;
// with no channel in use a tick is accepted in idle and the block stays there.
// rst_n is synchronous; after it all counts read as never used and are
// rewritten to zero on the first visit with the channel enabled, since every beat flag resets set.
// Input is not taken while events of the previous item are still queued.
module multi_channel_heartbeat_watchdog
  import mchw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mchw_in_if.sink     in_ch,
  mchw_out_if.source  out_ch,
  mchw_cfg_if.sink    cfg_ch
);

  mchw_state_t state_r, state_nxt;

  logic [ACT_W-1:0]      active_r;
  logic [LIMIT_W-1:0]    limit_r [LIMIT_REGS];
  logic [CHANNELS-1:0]   pend_r, pend_nxt;
  logic [CHANNELS-1:0]   en_r, en_nxt;
  logic [CHANNELS-1:0]   evv_r, evv_nxt;
  kind_t                 evk_r [CHANNELS];
  kind_t                 evk_nxt [CHANNELS];
  logic [ACT_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                  ev_vld_r, ev_vld_nxt;
  logic [ADDR_W-1:0]     ev_idx_r, ev_idx_nxt;

  logic [ACT_W-1:0]      used;
  logic                  in_acc, out_acc, cfg_acc, ch_ok;
  logic [CFG_IDX_W-1:0]  lim_wsel;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;

  logic [CMP_W-1:0]      cnt_x, lim_x, half_x;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [CHANNELS-1:0]   sel_oh;
  logic [ADDR_W-1:0]     sel_idx;
  logic                  sel_last;

  // Handshakes and channel count
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign used     = (active_r > ACT_W'(CHANNELS)) ? ACT_W'(CHANNELS) : active_r;
  assign ch_ok    = {1'b0, in_ch.channel} < used;
  assign lim_wsel = cfg_ch.reg_index - REG_LIMIT0;

  // Idle count store
  mchw_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CHANNELS)
  ) u_count_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Count evaluation operands
  assign cnt_x   = CMP_W'(mem_rdata);
  assign lim_x   = CMP_W'(limit_r[LIM_IDX_W'(ev_idx_r)]);
  assign half_x  = lim_x >> 1;
  assign cnt_inc = (mem_rdata == '1) ? mem_rdata : mem_rdata + COUNT_BITS'(1);

  // Lowest queued event goes out first
  assign sel_oh   = evv_r & (~evv_r + CHANNELS'(1));
  assign sel_last = (evv_r == sel_oh);
  always_comb begin
    sel_idx = '0;
    for (int k = CHANNELS - 1; k >= 0; k--) begin
      if (evv_r[k]) begin
        sel_idx = ADDR_W'(k);
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.operation == OP_BEAT) begin
            if (ch_ok) state_nxt = ST_DRAIN;
          end else if (used != '0) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_idx_r == used - ACT_W'(1)) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (evv_nxt == '0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ch.ready          = (state_r == ST_IDLE);
    cfg_ch.ready         = 1'b1;
    out_ch.valid         = (state_r == ST_DRAIN) && (evv_r != '0);
    out_ch.event_channel = CH_W'(sel_idx);
    out_ch.event_kind    = evk_r[sel_idx];
    out_ch.last_event    = sel_last;
    mem_raddr            = scan_idx_r[ADDR_W-1:0];
  end

  // Flags, event queue, scan pipeline and count write-back
  always_comb begin
    pend_nxt     = pend_r;
    en_nxt       = en_r;
    evv_nxt      = evv_r;
    evk_nxt      = evk_r;
    scan_idx_nxt = scan_idx_r;
    ev_vld_nxt   = 1'b0;
    ev_idx_nxt   = ev_idx_r;
    mem_we       = 1'b0;
    mem_waddr    = ev_idx_r;
    mem_wdata    = cnt_inc;

    // heartbeat or start of tick
    if (state_r == ST_IDLE && in_acc) begin
      scan_idx_nxt = '0;
      if (in_ch.operation == OP_BEAT && ch_ok) begin
        pend_nxt[in_ch.channel[ADDR_W-1:0]] = 1'b1;
        en_nxt[in_ch.channel[ADDR_W-1:0]]   = in_ch.enable_flag;
        evv_nxt[in_ch.channel[ADDR_W-1:0]]  = 1'b1;
        evk_nxt[in_ch.channel[ADDR_W-1:0]]  = KIND_BEAT;
      end
    end

    // read stage: one entry per cycle
    if (state_r == ST_SCAN) begin
      ev_vld_nxt   = 1'b1;
      ev_idx_nxt   = scan_idx_r[ADDR_W-1:0];
      scan_idx_nxt = scan_idx_r + ACT_W'(1);
    end

    // evaluate stage: entry read last cycle, written back now
    if (ev_vld_r && en_r[ev_idx_r]) begin
      if (pend_r[ev_idx_r]) begin
        pend_nxt[ev_idx_r] = 1'b0;
        mem_we             = 1'b1;
        mem_wdata          = '0;
      end else if (cnt_x < lim_x) begin
        mem_we = 1'b1;
        if (cnt_x == half_x) begin
          evv_nxt[ev_idx_r] = 1'b1;
          evk_nxt[ev_idx_r] = KIND_PRE;
        end
      end else if (cnt_x == lim_x) begin
        mem_we            = 1'b1;
        evv_nxt[ev_idx_r] = 1'b1;
        evk_nxt[ev_idx_r] = KIND_TIMEOUT;
      end
    end

    // drain: retire the delivered event
    if (out_acc) begin
      evv_nxt[sel_idx] = 1'b0;
    end

    // enable mask write reloads every channel enable
    if (cfg_acc && cfg_ch.reg_index == REG_MASK) begin
      for (int k = 0; k < CHANNELS; k++) begin
        en_nxt[k] = cfg_ch.wdata[k];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pend_r     <= '1;
      en_r       <= '0;
      evv_r      <= '0;
      scan_idx_r <= '0;
      ev_vld_r   <= 1'b0;
      ev_idx_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      pend_r     <= pend_nxt;
      en_r       <= en_nxt;
      evv_r      <= evv_nxt;
      scan_idx_r <= scan_idx_nxt;
      ev_vld_r   <= ev_vld_nxt;
      ev_idx_r   <= ev_idx_nxt;
    end
  end

  // Event kinds (payload)
  always_ff @(posedge clk) begin
    evk_r <= evk_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      for (int k = 0; k < LIMIT_REGS; k++) begin
        limit_r[k] <= '0;
      end
    end else if (cfg_acc) begin
      if (cfg_ch.reg_index == REG_ACTIVE) begin
        active_r <= cfg_ch.wdata[ACT_W-1:0];
      end else if (cfg_ch.reg_index >= REG_LIMIT0 && cfg_ch.reg_index <= REG_LIMIT3) begin
        limit_r[lim_wsel[LIM_IDX_W-1:0]] <= cfg_ch.wdata[LIMIT_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  // read and write-back in the scan never hit the same entry
  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("count RAM read and write hit the same entry");

  // a new item is only taken with an empty event queue
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (evv_r == '0))
    else $error("input ready with events still queued");

  // heartbeat to a channel in use yields one final event next cycle
  a_beat_event: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.operation == OP_BEAT && ch_ok) |=>
      (out_ch.valid && out_ch.last_event))
    else $error("heartbeat event missing");

  // last flag only on the sole remaining event
  a_last_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last_event) |-> $onehot(evv_r))
    else $error("last event flagged with more events queued");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for multi_channel_heartbeat_watchdog: directed and random
// heartbeat/tick traffic, with an in-bench watchdog model checking every event beat.
// Depends on mchw_pkg, mchw_in_if, mchw_out_if, mchw_cfg_if and the watchdog RTL.
module tb_top;
  import mchw_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT  = 10;
  // Register indexes past the last limit register; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_LIMIT3 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_LIMIT3 + 3'd2;

  typedef struct {
    logic [CH_W-1:0] channel;
    kind_t           kind;
    logic            last;
  } watchdog_event_t;

  logic clk;
  logic rst_n;

  mchw_in_if  in_if ();
  mchw_out_if out_if ();
  mchw_cfg_if cfg_if ();

  multi_channel_heartbeat_watchdog u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Watchdog model state and register copies
  logic                  beat_seen   [CHANNELS];
  logic                  watch_en    [CHANNELS];
  logic [COUNT_BITS-1:0] idle_scans  [CHANNELS];
  logic [ACT_W-1:0]      active_reg;
  logic [LIMIT_W-1:0]    limit_reg   [LIMIT_REGS];

  watchdog_event_t expected_events[$];
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Fail-safe end of run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver stalls, re-rolled every falling edge
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Model: channels currently in use
  function automatic int channels_in_use();
    return (active_reg > CHANNELS) ? CHANNELS : int'(active_reg);
  endfunction

  // Model: register write
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ACTIVE: active_reg = data[ACT_W-1:0];
      REG_MASK: begin
        for (int i = 0; i < CHANNELS; i++) watch_en[i] = data[i];
      end
      default: begin
        if (idx >= REG_LIMIT0 && idx <= REG_LIMIT3)
          limit_reg[idx - REG_LIMIT0] = data[LIMIT_W-1:0];
      end
    endcase
  endfunction

  // Model: events caused by one accepted input beat
  function automatic void predict_events(logic op, logic [CH_W-1:0] ch, logic en);
    watchdog_event_t fresh[$];
    logic [COUNT_BITS-1:0] lim;
    int used;
    used = channels_in_use();
    if (op == OP_BEAT) begin
      if (int'(ch) < used) begin
        beat_seen[ch] = 1'b1;
        watch_en[ch]  = en;
        fresh.push_back('{channel: ch, kind: KIND_BEAT, last: 1'b0});
      end
    end else begin
      for (int i = 0; i < used; i++) begin
        lim = COUNT_BITS'(limit_reg[i]);
        if (!watch_en[i]) continue;
        if (beat_seen[i]) begin
          beat_seen[i]  = 1'b0;
          idle_scans[i] = '0;
          continue;
        end
        if (idle_scans[i] < lim) begin
          if (idle_scans[i] == (lim >> 1))
            fresh.push_back('{channel: CH_W'(i), kind: KIND_PRE, last: 1'b0});
        end else if (idle_scans[i] == lim) begin
          fresh.push_back('{channel: CH_W'(i), kind: KIND_TIMEOUT, last: 1'b0});
        end else begin
          continue;
        end
        if (idle_scans[i] != '1) idle_scans[i] = idle_scans[i] + 1'b1;
      end
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    foreach (fresh[k]) expected_events.push_back(fresh[k]);
  endfunction

  // Compare one event beat against the oldest expectation
  function automatic void check_result();
    watchdog_event_t want;
    if (expected_events.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: unexpected event beat ch %0d kind %0d last %0d", $time,
                 out_if.event_channel, out_if.event_kind, out_if.last_event);
    end else begin
      want = expected_events.pop_front();
      if (want.channel !== out_if.event_channel || want.kind !== out_if.event_kind ||
          want.last !== out_if.last_event) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: event beat exp ch %0d kind %0d last %0d, got ch %0d kind %0d last %0d",
                   $time, want.channel, want.kind, want.last, out_if.event_channel,
                   out_if.event_kind, out_if.last_event);
      end
    end
  endfunction

  // Monitor: results first, then inputs and register writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) check_result();
      if (in_if.valid && in_if.ready)
        predict_events(in_if.operation, in_if.channel, in_if.enable_flag);
      if (cfg_if.valid && cfg_if.ready) apply_register(cfg_if.reg_index, cfg_if.wdata);
    end
  end

  // Send one input beat, with random sender gaps ahead of it
  task automatic send_item(input logic op, input logic [CH_W-1:0] ch, input logic en);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid       <= 1'b0;
      in_if.operation   <= 1'($urandom());
      in_if.channel     <= CH_W'($urandom());
      in_if.enable_flag <= 1'($urandom());
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.channel     <= ch;
    in_if.enable_flag <= en;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stop sending, wait for all expected events, then let the block settle
  task automatic drain_results(input int settle);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Write all six registers; unused upper data bits carry random junk
  task automatic apply_settings(input logic [ACT_W-1:0] act, input logic [MASK_W-1:0] mask,
                                input logic [LIMIT_W-1:0] l0, input logic [LIMIT_W-1:0] l1,
                                input logic [LIMIT_W-1:0] l2, input logic [LIMIT_W-1:0] l3);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom());
    data[ACT_W-1:0] = act;
    write_reg(REG_ACTIVE, data);
    data = CFG_DATA_W'($urandom());
    data[MASK_W-1:0] = mask;
    write_reg(REG_MASK, data);
    write_reg(REG_LIMIT0,          l0);
    write_reg(REG_LIMIT0 + 3'd1,   l1);
    write_reg(REG_LIMIT0 + 3'd2,   l2);
    write_reg(REG_LIMIT3,          l3);
  endtask

  // Mostly small limits so pre-timeouts and timeouts show up often
  function automatic logic [LIMIT_W-1:0] pick_limit();
    int r;
    r = $urandom_range(99);
    if (r < 70) return LIMIT_W'($urandom_range(0, 8));
    if (r < 85) return LIMIT_W'($urandom_range(9, 40));
    if (r < 93) return '1;
    return LIMIT_W'($urandom());
  endfunction

  task automatic random_settings();
    logic [ACT_W-1:0]  act;
    logic [MASK_W-1:0] mask;
    act  = ($urandom_range(99) < 60) ? ACT_W'(CHANNELS) : ACT_W'($urandom());
    mask = ($urandom_range(99) < 60) ? '1 : MASK_W'($urandom());
    apply_settings(act, mask, pick_limit(), pick_limit(), pick_limit(), pick_limit());
  endtask

  // After reset nothing is active: beats are dropped, ticks are quiet,
  // and writes to spare register indexes go nowhere
  task automatic test_reset_state();
    send_item(OP_BEAT, 2'd0, 1'b1);
    send_item(OP_TICK, 2'd2, 1'b0);
    drain_results(SETTLE_CYCLES);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 16'h5A5A);
  endtask

  // Oversized channel count, all enabled, zero limits: immediate timeouts
  task automatic test_zero_limits();
    apply_settings(3'd7, 4'hF, '0, '0, '0, '0);
    send_item(OP_TICK, 2'd3, 1'b1);
    send_item(OP_TICK, 2'd1, 1'b0);
    send_item(OP_TICK, 2'd0, 1'b1);
    send_item(OP_BEAT, 2'd3, 1'b1);
    send_item(OP_TICK, 2'd3, 1'b0);
    send_item(OP_TICK, 2'd0, 1'b0);
    drain_results(SETTLE_CYCLES);
  endtask

  // Pre-timeout at half the limit, limit of one, largest limit, enable by beat
  task automatic test_half_limits();
    apply_settings(3'd4, 4'b1011, 16'd4, 16'd1, 16'hFFFF, 16'd2);
    send_item(OP_BEAT, 2'd2, 1'b1);
    repeat (7) send_item(OP_TICK, 2'd0, 1'b0);
    send_item(OP_BEAT, 2'd0, 1'b0);
    send_item(OP_TICK, 2'd1, 1'b1);
    send_item(OP_TICK, 2'd2, 1'b1);
    drain_results(SETTLE_CYCLES);
  endtask

  // Beats above the active count are ignored; ticks skip those channels
  task automatic test_inactive_channels();
    apply_settings(3'd2, 4'hF, 16'd3, 16'd3, 16'd3, 16'd3);
    send_item(OP_BEAT, 2'd2, 1'b1);
    send_item(OP_BEAT, 2'd3, 1'b0);
    send_item(OP_BEAT, 2'd1, 1'b1);
    send_item(OP_TICK, 2'd0, 1'b0);
    send_item(OP_TICK, 2'd3, 1'b0);
    drain_results(SETTLE_CYCLES);
  endtask

  // Random traffic: mostly ticks and beats to live channels, some stray beats
  task automatic test_random_phase(input int send_pct, input int recv_pct, input int items);
    int r;
    int used;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    random_settings();
    for (int n = 0; n < items; n++) begin
      if (n == items / 2) begin
        drain_results(SETTLE_CYCLES);
        random_settings();
      end else if ($urandom_range(24) == 0) begin
        drain_results(0);
      end
      used = channels_in_use();
      r = $urandom_range(99);
      if (r < 70 || used == 0)
        send_item(OP_TICK, CH_W'($urandom()), 1'($urandom()));
      else if (r < 90)
        send_item(OP_BEAT, CH_W'($urandom_range(0, used - 1)), $urandom_range(99) < 80);
      else
        send_item(OP_BEAT, CH_W'($urandom()), 1'($urandom()));
    end
    drain_results(SETTLE_CYCLES);
  endtask

  // Test sequence
  initial begin
    mismatches    = 0;
    send_idle_pct = 29;
    recv_idle_pct = 66;
    active_reg    = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      beat_seen[i]  = 1'b1;
      watch_en[i]   = 1'b0;
      idle_scans[i] = '0;
      limit_reg[i]  = '0;
    end
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_TICK;
    in_if.channel      = '0;
    in_if.enable_flag  = 1'b0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.reg_index   = REG_ACTIVE;
    cfg_if.wdata       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    test_reset_state();
    test_zero_limits();
    test_half_limits();
    test_inactive_channels();
    test_random_phase(29, 66, 52);
    test_random_phase(66, 29, 52);
    test_random_phase(0, 0, 52);

    if (expected_events.size() != 0) begin
      $display("%0t: %0d expected event beats never arrived", $time, expected_events.size());
      mismatches += expected_events.size();
    end
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
